// File: src/hsad_pkg.sv
package hsad_pkg;

	// Default number of pole pairs; one mechanical turn holds this many electrical turns.
	localparam int POLE_PAIRS_DEF = 4;

	localparam int CODE_W  = 3;
	localparam int ANGLE_W = 16;
	localparam int TURN_W  = 4;
	localparam int POS_W   = 3;

	// Hall codes that name no sector.
	localparam logic [CODE_W-1:0] HALL_NONE_LO = 3'd0;
	localparam logic [CODE_W-1:0] HALL_NONE_HI = 3'd7;

	// Hall codes in sequence order 1,3,2,6,4,5.
	localparam logic [CODE_W-1:0] HALL_SEC0 = 3'd1;
	localparam logic [CODE_W-1:0] HALL_SEC1 = 3'd3;
	localparam logic [CODE_W-1:0] HALL_SEC2 = 3'd2;
	localparam logic [CODE_W-1:0] HALL_SEC3 = 3'd6;
	localparam logic [CODE_W-1:0] HALL_SEC4 = 3'd4;
	localparam logic [CODE_W-1:0] HALL_SEC5 = 3'd5;

	// Positions of the first and last sector in the sequence; the turn boundary lies between them.
	localparam logic [POS_W-1:0] SEQ_FIRST = 3'd0;
	localparam logic [POS_W-1:0] SEQ_LAST  = 3'd5;

	// Electrical sector angles, in sequence order.
	localparam logic [ANGLE_W-1:0] SECT_ANG0 = 16'h0000;
	localparam logic [ANGLE_W-1:0] SECT_ANG1 = 16'h2AAA;
	localparam logic [ANGLE_W-1:0] SECT_ANG2 = 16'h5554;
	localparam logic [ANGLE_W-1:0] SECT_ANG3 = 16'h7FFF;
	localparam logic [ANGLE_W-1:0] SECT_ANG4 = 16'hAAA8;
	localparam logic [ANGLE_W-1:0] SECT_ANG5 = 16'hD552;
	localparam logic [ANGLE_W-1:0] FULL_TURN = 16'hFFFF;

	typedef enum logic [1:0] {
		FAULT_NONE  = 2'd0,
		FAULT_VALUE = 2'd1,
		FAULT_SEQ   = 2'd2
	} fault_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] angle;
		logic [TURN_W-1:0]  turn;
		fault_t             fault;
	} hsad_result_t;

	// Position of a valid code within the sector sequence.
	function automatic logic [POS_W-1:0] seq_pos(input logic [CODE_W-1:0] code);
		logic [POS_W-1:0] pos;
		begin
			unique case (code)
				HALL_SEC1: pos = 3'd1;
				HALL_SEC2: pos = 3'd2;
				HALL_SEC3: pos = 3'd3;
				HALL_SEC4: pos = 3'd4;
				HALL_SEC5: pos = 3'd5;
				default:   pos = SEQ_FIRST;
			endcase
			return pos;
		end
	endfunction

endpackage

// File: src/hsad_track.sv
module hsad_track import hsad_pkg::*; #(
	parameter int POLE_PAIRS = POLE_PAIRS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [CODE_W-1:0]   code,
	output hsad_result_t        result
);

	// Sector angles scaled to one electrical turn, and the angle of one electrical turn.
	localparam logic [ANGLE_W-1:0] SECT_DIV0 = ANGLE_W'(SECT_ANG0 / POLE_PAIRS);
	localparam logic [ANGLE_W-1:0] SECT_DIV1 = ANGLE_W'(SECT_ANG1 / POLE_PAIRS);
	localparam logic [ANGLE_W-1:0] SECT_DIV2 = ANGLE_W'(SECT_ANG2 / POLE_PAIRS);
	localparam logic [ANGLE_W-1:0] SECT_DIV3 = ANGLE_W'(SECT_ANG3 / POLE_PAIRS);
	localparam logic [ANGLE_W-1:0] SECT_DIV4 = ANGLE_W'(SECT_ANG4 / POLE_PAIRS);
	localparam logic [ANGLE_W-1:0] SECT_DIV5 = ANGLE_W'(SECT_ANG5 / POLE_PAIRS);
	localparam logic [ANGLE_W-1:0] TURN_STEP = ANGLE_W'(FULL_TURN / POLE_PAIRS);
	localparam logic [TURN_W:0]    PP_EXT    = (TURN_W+1)'(POLE_PAIRS);
	localparam logic [TURN_W-1:0]  TURN_MAX  = TURN_W'(POLE_PAIRS - 1);
	localparam int                 PROD_W    = ANGLE_W + TURN_W;

	logic [CODE_W-1:0]  last_code_q;
	logic [TURN_W-1:0]  turn_count_q;
	logic [ANGLE_W-1:0] held_angle_q;

	logic [CODE_W-1:0]  last_code_d;
	logic [TURN_W-1:0]  turn_count_d;
	logic [ANGLE_W-1:0] held_angle_d;

	logic [POS_W-1:0]   pos_new;
	logic [POS_W-1:0]   pos_old;
	logic               fwd;
	logic               back;
	logic [ANGLE_W-1:0] sect_div;
	logic [PROD_W-1:0]  turn_ofs;
	fault_t             fault_d;

	assign pos_new = seq_pos(code);
	assign pos_old = seq_pos(last_code_q);
	assign fwd  = (pos_old == SEQ_LAST) ? (pos_new == SEQ_FIRST) : (pos_new == pos_old + 3'd1);
	assign back = (pos_new == SEQ_LAST) ? (pos_old == SEQ_FIRST) : (pos_old == pos_new + 3'd1);

	always_comb begin
		unique case (code)
			HALL_SEC1: sect_div = SECT_DIV1;
			HALL_SEC2: sect_div = SECT_DIV2;
			HALL_SEC3: sect_div = SECT_DIV3;
			HALL_SEC4: sect_div = SECT_DIV4;
			HALL_SEC5: sect_div = SECT_DIV5;
			default:   sect_div = SECT_DIV0;
		endcase
	end

	always_comb begin
		last_code_d  = last_code_q;
		turn_count_d = turn_count_q;
		fault_d      = FAULT_NONE;
		if (code == HALL_NONE_LO || code == HALL_NONE_HI) begin
			last_code_d = HALL_NONE_LO;
			fault_d     = FAULT_VALUE;
		end else if (code != last_code_q) begin
			if (last_code_q != HALL_NONE_LO && !fwd && !back) begin
				last_code_d = HALL_NONE_LO;
				fault_d     = FAULT_SEQ;
			end else begin
				last_code_d = code;
				if (last_code_q != HALL_NONE_LO && fwd && pos_old == SEQ_LAST) begin
					turn_count_d = ({1'b0, turn_count_q} + 1'b1 >= PP_EXT) ? '0
						: turn_count_q + 1'b1;
				end else if (last_code_q != HALL_NONE_LO && back && pos_new == SEQ_LAST) begin
					turn_count_d = (turn_count_q == '0) ? TURN_MAX : turn_count_q - 1'b1;
				end
			end
		end
	end

	// The angle only moves when a sector code is taken over.
	assign turn_ofs = PROD_W'(turn_count_d) * PROD_W'(TURN_STEP);

	always_comb begin
		held_angle_d = held_angle_q;
		if (fault_d == FAULT_NONE && code != last_code_q) begin
			held_angle_d = sect_div + turn_ofs[ANGLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_code_q  <= HALL_NONE_LO;
			turn_count_q <= '0;
			held_angle_q <= '0;
		end else if (step) begin
			last_code_q  <= last_code_d;
			turn_count_q <= turn_count_d;
			held_angle_q <= held_angle_d;
		end
	end

	assign result.angle = held_angle_d;
	assign result.turn  = turn_count_d;
	assign result.fault = fault_d;

endmodule

// File: src/hall_sensor_angle_decoder_core.sv
// Channel   Handshake             Payload
// in        in_valid / in_ready   hall_code
// out       out_valid / out_ready unaligned_angle, aligned_angle, turn_index, fault
// cfg       cfg_valid / cfg_ready sync_offset
//
// A sample beat is registered in the input register, decoded from there, and its result lands
// in the output register, from which it is offered.
// One sample beat is taken every cycle while in_ready is high; the decode state updates as the beat moves on.
// Reset clears the sector memory, the turn count, the held angle and the offset.
// When the output stalls, one more sample waits in the input register before in_ready drops.
module hall_sensor_angle_decoder_core import hsad_pkg::*; #(
	parameter int POLE_PAIRS = POLE_PAIRS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CODE_W-1:0]   hall_code,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [ANGLE_W-1:0]  unaligned_angle,
	output logic [ANGLE_W-1:0]  aligned_angle,
	output logic [TURN_W-1:0]   turn_index,
	output logic [1:0]          fault,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [ANGLE_W-1:0]  sync_offset
);

	logic               valid_s1;
	logic [CODE_W-1:0]  code_s1;
	logic               valid_s2;
	hsad_result_t       res_s2;
	logic [ANGLE_W-1:0] aligned_s2;
	logic [ANGLE_W-1:0] sync_offset_q;
	logic               advance;
	hsad_result_t       res;

	// The decode stage moves whenever the output register is empty or being drained.
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	// The offset register always takes a write.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_offset_q <= '0;
		end else if (cfg_valid) begin
			sync_offset_q <= sync_offset;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			code_s1 <= hall_code;
		end
	end

	// Sector tracking and angle computation; state commits as the item moves on.
	hsad_track #(
		.POLE_PAIRS(POLE_PAIRS)
	) u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.code   (code_s1),
		.result (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_s2     <= res;
			aligned_s2 <= res.angle + sync_offset_q;
		end
	end

	assign out_valid       = valid_s2;
	assign unaligned_angle = res_s2.angle;
	assign aligned_angle   = aligned_s2;
	assign turn_index      = res_s2.turn;
	assign fault           = res_s2.fault;

endmodule

// File: src/hsad_checker.sv
module hsad_checker import hsad_pkg::*; #(
	parameter int POLE_PAIRS = POLE_PAIRS_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [ANGLE_W-1:0]  unaligned_angle,
	input logic [ANGLE_W-1:0]  aligned_angle,
	input logic [TURN_W-1:0]   turn_index,
	input logic [1:0]          fault
);

	localparam logic [TURN_W:0] PP_EXT = (TURN_W+1)'(POLE_PAIRS);

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(unaligned_angle)
			&& $stable(aligned_angle) && $stable(turn_index) && $stable(fault))
		else $error("result beat changed while stalled");

	// With nothing waiting at the output the input side never stalls.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// The turn count stays below the pole pair count.
	a_turn_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> {1'b0, turn_index} < PP_EXT)
		else $error("turn index out of range");

	// No result is pending right after reset.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result pending after reset");

endmodule

bind hall_sensor_angle_decoder_core hsad_checker #(.POLE_PAIRS(POLE_PAIRS)) u_hsad_checker (.*);
